// File: hw/rtl/bbbd_pkg.sv
// ----------------------------------------------------------------------------
// bbbd_pkg
// Types and constants shared by the beam-break baseline detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bbbd_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int DIFF_BITS      = 11;
  localparam int STRENGTH_BITS  = 11;
  localparam int SHIFT_BITS     = 4;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 11;
  localparam int SLOW_SHIFT     = 10;
  localparam int DIFF_LIMIT     = 1023;
  localparam int STRENGTH_LIMIT = 2047;

  // Reset values of the configuration registers
  localparam int DELTA_ON_RST   = 40;
  localparam int DELTA_OFF_RST  = 20;
  localparam int BASE_SHIFT_RST = 6;
  localparam int BROKEN_THR_RST = 30;

  typedef enum logic [1:0] {
    CMD_UPDATE  = 2'd0,
    CMD_CAPTURE = 2'd1,
    CMD_START   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DELTA_ON    = 3'd0,
    REG_DELTA_OFF   = 3'd1,
    REG_BASE_SHIFT  = 3'd2,
    REG_DIFF_INVERT = 3'd3,
    REG_BROKEN_THR  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [SAMPLE_BITS-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [DIFF_BITS-1:0] difference;
    logic [STRENGTH_BITS-1:0]    strength;
    logic                        broken;
    logic                        latched;
  } out_word_t;

endpackage

`default_nettype wire

// File: hw/rtl/beam_break_baseline_detector.sv
// The input register takes each accepted input word; its result word goes to
// the result register and out_, and waits there while out_stall holds it.
// Throughput: one word per cycle when out_stall is low; the baseline update is
// combinational between the input register and the result register.
// Reset (rst_n low, synchronous): baseline, stored difference, idle offset and
// hysteresis latch clear, configuration registers return to their defaults.
// ----------------------------------------------------------------------------
// beam_break_baseline_detector
// Adaptive baseline with hysteresis latch and beam-break strength detection.
// ----------------------------------------------------------------------------
`default_nettype none

module beam_break_baseline_detector (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire bbbd_pkg::in_word_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output bbbd_pkg::out_word_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bbbd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [bbbd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SW = bbbd_pkg::SAMPLE_BITS;
  localparam int DW = bbbd_pkg::DIFF_BITS;
  localparam int WW = SW + 1;  // working width of sample differences

  // Configuration registers
  logic [9:0]                          delta_on_r;
  logic [9:0]                          delta_off_r;
  logic [bbbd_pkg::SHIFT_BITS-1:0]     base_shift_r;
  logic                                diff_invert_r;
  logic [bbbd_pkg::STRENGTH_BITS-1:0]  broken_thr_r;

  // Block state
  logic [SW-1:0]        baseline_r, baseline_nxt;
  logic signed [DW-1:0] last_diff_r, last_diff_nxt;
  logic signed [DW-1:0] idle_off_r, idle_off_nxt;
  logic                 idle_valid_r, idle_valid_nxt;
  logic                 latch_r, latch_nxt;

  // Pipeline
  bbbd_pkg::in_word_t  s1_r;
  logic                s1_v_r, s1_v_nxt;
  bbbd_pkg::out_word_t out_r, out_nxt;
  logic                out_v_r, out_v_nxt;
  logic                adv;
  logic                in_acc;

  assign adv       = !out_v_r || !out_stall;
  assign in_stall  = s1_v_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign s1_v_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = adv ? s1_v_r : out_v_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Datapath
  logic signed [WW-1:0]   smp_s, base_s, base_new_s;
  logic signed [WW-1:0]   now_diff, new_diff, delta, step;
  logic [WW-1:0]          mag;
  logic                   latch_upd;
  logic [bbbd_pkg::SHIFT_BITS-1:0] sh;
  logic [SW-1:0]          base_upd;
  logic signed [31:0]     new_diff_w;
  logic signed [DW-1:0]   diff_clamped;
  logic signed [DW:0]     str_raw;
  logic [DW:0]            str_abs;
  logic [bbbd_pkg::STRENGTH_BITS-1:0] strength;

  always_comb begin
    smp_s      = $signed({1'b0, s1_r.sample});
    base_s     = $signed({1'b0, baseline_r});
    now_diff   = diff_invert_r ? (smp_s - base_s) : (base_s - smp_s);
    mag        = now_diff[WW-1] ? WW'(-now_diff) : WW'(now_diff);
    if (latch_r) begin
      latch_upd = !(mag < WW'(delta_off_r));
    end else begin
      latch_upd = mag > WW'(delta_on_r);
    end
    sh         = latch_upd ? bbbd_pkg::SHIFT_BITS'(bbbd_pkg::SLOW_SHIFT) : base_shift_r;
    delta      = smp_s - base_s;
    // arithmetic shift floors towards minus infinity
    step       = delta >>> sh;
    base_new_s = base_s + step;
    base_upd   = base_new_s[SW-1:0];
    new_diff   = diff_invert_r ? (smp_s - base_new_s) : (base_new_s - smp_s);
    new_diff_w = 32'(new_diff);
    if (new_diff_w > bbbd_pkg::DIFF_LIMIT) begin
      diff_clamped = DW'(bbbd_pkg::DIFF_LIMIT);
    end else if (new_diff_w < -bbbd_pkg::DIFF_LIMIT) begin
      diff_clamped = DW'(-bbbd_pkg::DIFF_LIMIT);
    end else begin
      diff_clamped = new_diff_w[DW-1:0];
    end
  end

  always_comb begin
    baseline_nxt   = baseline_r;
    last_diff_nxt  = last_diff_r;
    idle_off_nxt   = idle_off_r;
    idle_valid_nxt = idle_valid_r;
    latch_nxt      = latch_r;
    if (s1_v_r && adv) begin
      unique case (s1_r.cmd)
        bbbd_pkg::CMD_UPDATE: begin
          latch_nxt     = latch_upd;
          baseline_nxt  = base_upd;
          last_diff_nxt = diff_clamped;
        end
        bbbd_pkg::CMD_CAPTURE: begin
          idle_off_nxt   = last_diff_r;
          idle_valid_nxt = 1'b1;
        end
        bbbd_pkg::CMD_START: begin
          baseline_nxt   = s1_r.sample;
          idle_off_nxt   = '0;
          idle_valid_nxt = 1'b0;
          latch_nxt      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    str_raw = idle_valid_nxt ? ((DW+1)'(last_diff_nxt) - (DW+1)'(idle_off_nxt))
                             : (DW+1)'(last_diff_nxt);
    str_abs = str_raw[DW] ? (DW+1)'(-str_raw) : (DW+1)'(str_raw);
    if (str_abs > (DW+1)'(bbbd_pkg::STRENGTH_LIMIT)) begin
      strength = bbbd_pkg::STRENGTH_BITS'(bbbd_pkg::STRENGTH_LIMIT);
    end else begin
      strength = str_abs[bbbd_pkg::STRENGTH_BITS-1:0];
    end
    out_nxt.difference = last_diff_nxt;
    out_nxt.strength   = strength;
    out_nxt.broken     = strength > broken_thr_r;
    out_nxt.latched    = latch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      baseline_r    <= '0;
      last_diff_r   <= '0;
      idle_off_r    <= '0;
      idle_valid_r  <= 1'b0;
      latch_r       <= 1'b0;
      delta_on_r    <= 10'(bbbd_pkg::DELTA_ON_RST);
      delta_off_r   <= 10'(bbbd_pkg::DELTA_OFF_RST);
      base_shift_r  <= bbbd_pkg::SHIFT_BITS'(bbbd_pkg::BASE_SHIFT_RST);
      diff_invert_r <= 1'b0;
      broken_thr_r  <= bbbd_pkg::STRENGTH_BITS'(bbbd_pkg::BROKEN_THR_RST);
    end else begin
      s1_v_r        <= s1_v_nxt;
      out_v_r       <= out_v_nxt;
      baseline_r    <= baseline_nxt;
      last_diff_r   <= last_diff_nxt;
      idle_off_r    <= idle_off_nxt;
      idle_valid_r  <= idle_valid_nxt;
      latch_r       <= latch_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bbbd_pkg::REG_DELTA_ON:    delta_on_r    <= cfg_data[9:0];
          bbbd_pkg::REG_DELTA_OFF:   delta_off_r   <= cfg_data[9:0];
          bbbd_pkg::REG_BASE_SHIFT:  base_shift_r  <= cfg_data[bbbd_pkg::SHIFT_BITS-1:0];
          bbbd_pkg::REG_DIFF_INVERT: diff_invert_r <= cfg_data[0];
          bbbd_pkg::REG_BROKEN_THR:  broken_thr_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: hold the word while the stage cannot advance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
    if (adv && s1_v_r) begin
      out_r <= out_nxt;
    end
  end

  // Assertions
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_v_r && out_stall))
    else $error("input stalled while output stage free");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && adv) |=> out_v_r)
    else $error("word lost between stages");

  a_idle_offset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !idle_valid_r |-> (idle_off_r == '0))
    else $error("idle offset set without capture");

  a_start_clears_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && adv && s1_r.cmd == bbbd_pkg::CMD_START) |=> (!latch_r && !idle_valid_r))
    else $error("start did not clear latch and idle capture");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the beam-break baseline detector word by word. A directed list of
// commands at the field extremes opens the run, followed by random light-gate
// traces under several register settings. Every accepted input word is run
// through a local model of the detector, and every result word is compared
// field by field with the oldest expected word. Sender gaps and receiver stalls
// are random, with one long receiver hold-off to back the block up.
// ----------------------------------------------------------------------------

module testbench;

  localparam int N_DIR          = 24;
  localparam int PHASES         = 7;
  localparam int WORDS_PER_PHASE = 190;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    bbbd_pkg::cmd_t                   cmd;
    logic [bbbd_pkg::SAMPLE_BITS-1:0] sample;
    bit                               typed;
    int                               w_diff;
    int                               w_str;
    bit                               w_brk;
    bit                               w_lat;
  } dir_row_t;

  logic                collect_dummy_unused_never;
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  bbbd_pkg::in_word_t  in_data   = '0;
  logic                out_stall = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [bbbd_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [bbbd_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                in_stall;
  logic                out_valid;
  bbbd_pkg::out_word_t out_data;
  logic                cfg_ready;

  // Register mirror, at reset values
  int thr_on    = bbbd_pkg::DELTA_ON_RST;
  int thr_off   = bbbd_pkg::DELTA_OFF_RST;
  int avg_shift = bbbd_pkg::BASE_SHIFT_RST;
  int diff_inv  = 0;
  int break_thr = bbbd_pkg::BROKEN_THR_RST;

  // Detector state
  int det_baseline    = 0;
  int det_last_diff   = 0;
  int det_idle_offset = 0;
  bit det_idle_valid  = 1'b0;
  bit det_latch       = 1'b0;

  bbbd_pkg::out_word_t expected_words[$];
  int        n_errors    = 0;
  int        n_results   = 0;
  int        idle_cycles = 0;
  int        burst_left  = 0;
  bit        hold_off_req = 1'b0;

  // Light-gate trace generator state
  int gate_level  = 600;
  int break_left  = 0;
  int break_depth = 0;

  dir_row_t dir_rows [N_DIR] = '{
    '{bbbd_pkg::CMD_NONE,    10'd0,    1'b1,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_CAPTURE, 10'd1023, 1'b1,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_START,   10'd0,    1'b1,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd0,    1'b1,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd1023, 1'b1, -1023, 1023, 1'b1, 1'b1},
    '{bbbd_pkg::CMD_CAPTURE, 10'd0,    1'b1, -1023,    0, 1'b0, 1'b1},
    '{bbbd_pkg::CMD_UPDATE,  10'd0,    1'b1,     0, 1023, 1'b1, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd1023, 1'b1, -1023,    0, 1'b0, 1'b1},
    '{bbbd_pkg::CMD_NONE,    10'd1023, 1'b1, -1023,    0, 1'b0, 1'b1},
    '{bbbd_pkg::CMD_START,   10'd1023, 1'b1, -1023, 1023, 1'b1, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd0,    1'b1,  1022, 1022, 1'b1, 1'b1},
    '{bbbd_pkg::CMD_UPDATE,  10'd1022, 1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd1000, 1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd960,  1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_CAPTURE, 10'd0,    1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd700,  1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd700,  1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd990,  1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_START,   10'd512,  1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd513,  1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd511,  1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd1023, 1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd341,  1'b0,     0,    0, 1'b0, 1'b0},
    '{bbbd_pkg::CMD_UPDATE,  10'd682,  1'b0,     0,    0, 1'b0, 1'b0}
  };

  beam_break_baseline_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Advance the detector by one command and return the result word it gives
  function automatic bbbd_pkg::out_word_t advance_detector(bbbd_pkg::in_word_t w);
    int smp;
    int now;
    int mag;
    int sh;
    int strength;
    bbbd_pkg::out_word_t r;
    smp = int'(w.sample);
    case (w.cmd)
      bbbd_pkg::CMD_UPDATE: begin
        now = diff_inv ? smp - det_baseline : det_baseline - smp;
        mag = (now < 0) ? -now : now;
        if (det_latch) begin
          if (mag < thr_off) det_latch = 1'b0;
        end else if (mag > thr_on) begin
          det_latch = 1'b1;
        end
        sh = det_latch ? bbbd_pkg::SLOW_SHIFT : avg_shift;
        // signed shift rounds towards minus infinity
        det_baseline = det_baseline + ((smp - det_baseline) >>> sh);
        now = diff_inv ? smp - det_baseline : det_baseline - smp;
        if (now > bbbd_pkg::DIFF_LIMIT) now = bbbd_pkg::DIFF_LIMIT;
        if (now < -bbbd_pkg::DIFF_LIMIT) now = -bbbd_pkg::DIFF_LIMIT;
        det_last_diff = now;
      end
      bbbd_pkg::CMD_CAPTURE: begin
        det_idle_offset = det_last_diff;
        det_idle_valid  = 1'b1;
      end
      bbbd_pkg::CMD_START: begin
        det_baseline    = smp;
        det_idle_offset = 0;
        det_idle_valid  = 1'b0;
        det_latch       = 1'b0;
      end
      default: ;
    endcase
    strength = det_idle_valid ? det_last_diff - det_idle_offset : det_last_diff;
    if (strength < 0) strength = -strength;
    if (strength > bbbd_pkg::STRENGTH_LIMIT) strength = bbbd_pkg::STRENGTH_LIMIT;
    r.difference = bbbd_pkg::DIFF_BITS'(det_last_diff);
    r.strength   = bbbd_pkg::STRENGTH_BITS'(strength);
    r.broken     = (strength > break_thr);
    r.latched    = det_latch;
    return r;
  endfunction

  // Mostly a steady gate level with small noise and beam-break dips, plus
  // starts, captures, idle codes and full-range noise
  function automatic bbbd_pkg::in_word_t next_gate_word();
    bbbd_pkg::in_word_t w;
    int pick;
    int s;
    pick = int'($urandom_range(0, 99));
    s = int'($urandom_range(0, 1023));
    if (pick < 3) begin
      w.cmd = bbbd_pkg::CMD_START;
      s = gate_level + int'($urandom_range(0, 16)) - 8;
    end else if (pick < 6) begin
      w.cmd = bbbd_pkg::CMD_CAPTURE;
    end else if (pick < 8) begin
      w.cmd = bbbd_pkg::CMD_NONE;
    end else begin
      w.cmd = bbbd_pkg::CMD_UPDATE;
      if (pick >= 14) begin
        if (break_left == 0 && $urandom_range(0, 29) == 0) begin
          break_left  = int'($urandom_range(3, 40));
          break_depth = int'($urandom_range(10, 700));
        end
        s = gate_level + int'($urandom_range(0, 16)) - 8;
        if (break_left > 0) begin
          s = s - break_depth;
          break_left--;
        end
        if ($urandom_range(0, 99) == 0) gate_level = int'($urandom_range(0, 1023));
      end
    end
    if (s < 0) s = 0;
    if (s > 1023) s = 1023;
    w.sample = bbbd_pkg::SAMPLE_BITS'(s);
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    n_errors++;
  endtask

  // Offer one register write and hold valid; the caller drops it
  task automatic write_reg(bbbd_pkg::reg_idx_t idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bbbd_pkg::CFG_DATA_BITS'(val);
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      bbbd_pkg::REG_DELTA_ON:    thr_on    = val & 'h3FF;
      bbbd_pkg::REG_DELTA_OFF:   thr_off   = val & 'h3FF;
      bbbd_pkg::REG_BASE_SHIFT:  avg_shift = val & 'hF;
      bbbd_pkg::REG_DIFF_INVERT: diff_inv  = val & 'h1;
      bbbd_pkg::REG_BROKEN_THR:  break_thr = val & 'h7FF;
      default: ;
    endcase
  endtask

  task automatic apply_setting(int on_v, int off_v, int sh_v, int inv_v, int thr_v);
    write_reg(bbbd_pkg::REG_DELTA_ON, on_v);
    write_reg(bbbd_pkg::REG_DELTA_OFF, off_v);
    write_reg(bbbd_pkg::REG_BASE_SHIFT, sh_v);
    write_reg(bbbd_pkg::REG_DIFF_INVERT, inv_v);
    write_reg(bbbd_pkg::REG_BROKEN_THR, thr_v);
    cfg_valid <= 1'b0;
  endtask

  // Offer one word, hold it until taken, then predict and maybe pause
  task automatic send_word(bbbd_pkg::in_word_t w, bit typed, bbbd_pkg::out_word_t want);
    bbbd_pkg::out_word_t predicted;
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = advance_detector(w);
    expected_words.push_back(typed ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(100, 300))
                                                : int'($urandom_range(0, 30));
    end
  endtask

  // Drop valid and wait until every result word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    bbbd_pkg::in_word_t  w;
    bbbd_pkg::out_word_t want;
    int p;
    int k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < N_DIR; k++) begin
      w.cmd           = dir_rows[k].cmd;
      w.sample        = dir_rows[k].sample;
      want.difference = bbbd_pkg::DIFF_BITS'(dir_rows[k].w_diff);
      want.strength   = bbbd_pkg::STRENGTH_BITS'(dir_rows[k].w_str);
      want.broken     = dir_rows[k].w_brk;
      want.latched    = dir_rows[k].w_lat;
      send_word(w, dir_rows[k].typed, want);
    end
    drain_results();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        1: apply_setting(0, 0, 0, 1, 0);
        2: apply_setting(1023, 1023, 15, 0, 2047);
        4: apply_setting(100, 10, 3, 1, 200);
        6: apply_setting(bbbd_pkg::DELTA_ON_RST, bbbd_pkg::DELTA_OFF_RST,
                         bbbd_pkg::BASE_SHIFT_RST, 0, bbbd_pkg::BROKEN_THR_RST);
        3, 5: apply_setting(int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
                            int'($urandom_range(0, 15)), int'($urandom_range(0, 1)),
                            $urandom_range(0, 1) ? int'($urandom_range(0, 80))
                                                 : int'($urandom_range(0, 2047)));
        default: ;
      endcase
      if (p == 1) hold_off_req = 1'b1;
      for (k = 0; k < WORDS_PER_PHASE; k++) send_word(next_gate_word(), 1'b0, '0);
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: stall in segments of random style, with one long hold-off
  initial begin : receiver
    int style;
    int seg_left;
    bit hold_done;
    style     = 0;
    seg_left  = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        seg_left = 0;
      end else begin
        if (seg_left == 0) begin
          style    = int'($urandom_range(0, 3));
          seg_left = int'($urandom_range(20, 200));
        end
        seg_left--;
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (seg_left % 4 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    bbbd_pkg::out_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      n_results++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
      end else begin
        want = expected_words.pop_front();
        if (out_data.difference !== want.difference)
          report_mismatch($sformatf("result %0d difference got %0d want %0d", n_results,
                                    out_data.difference, want.difference));
        if (out_data.strength !== want.strength)
          report_mismatch($sformatf("result %0d strength got %0d want %0d", n_results,
                                    out_data.strength, want.strength));
        if (out_data.broken !== want.broken)
          report_mismatch($sformatf("result %0d broken got %b want %b", n_results,
                                    out_data.broken, want.broken));
        if (out_data.latched !== want.latched)
          report_mismatch($sformatf("result %0d latched got %b want %b", n_results,
                                    out_data.latched, want.latched));
      end
    end
  end

  // Count cycles in which no word moves on any channel
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d results outstanding", expected_words.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: filelist.f
hw/rtl/bbbd_pkg.sv
hw/rtl/beam_break_baseline_detector.sv
dv/testbench.sv
